// ===== src/bdasc_pkg.sv =====
// Shared types, constants and helpers for the binary to decimal ASCII converter.
package bdasc_pkg;

    localparam int VALUE_BITS = 64;
    localparam int CHAR_BITS  = 6;
    localparam int BCD_BITS   = 4;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        DD_IDLE,
        DD_SHIFT,
        DD_HOLD
    } dabble_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_SEND
    } emit_state_t;

    // Double-dabble correction: add three to a digit of five or more before the shift.
    function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] d);
        logic [BCD_BITS-1:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

// ===== src/bdasc_dabble.sv =====
// Bit-serial double-dabble converter: one binary bit shifted into the BCD register per cycle.
module bdasc_dabble
    import bdasc_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start_valid,
    output logic                         start_ready,
    input  logic [VALUE_WIDTH-1:0]       start_value,
    output logic                         bcd_valid,
    input  logic                         bcd_ready,
    output logic [BCD_BITS*MAX_DIGITS-1:0] bcd_data
);

    localparam int BCD_W = BCD_BITS * MAX_DIGITS;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    dabble_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [BCD_W-1:0]       adj;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            adj[i*BCD_BITS +: BCD_BITS] = bcd_adjust(bcd_reg[i*BCD_BITS +: BCD_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DD_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        start_ready = 1'b0;
        bcd_valid   = 1'b0;
        case (state_reg)
            DD_IDLE: begin
                start_ready = 1'b1;
                if (start_valid) begin
                    bin_next   = start_value;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    state_next = DD_SHIFT;
                end
            end
            DD_SHIFT: begin
                // Correct, then shift the next binary bit in at the bottom.
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = DD_HOLD;
                end
            end
            DD_HOLD: begin
                bcd_valid = 1'b1;
                if (bcd_ready) begin
                    state_next = DD_IDLE;
                end
            end
            default: begin
                state_next = DD_IDLE;
            end
        endcase
    end

    assign bcd_data = bcd_reg;

endmodule

// ===== src/bdasc_emit.sv =====
// Digit emitter: skips leading zeros and sends one ASCII digit per transfer, most significant first.
module bdasc_emit
    import bdasc_pkg::*;
#(
    parameter int MAX_DIGITS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           bcd_valid,
    output logic                           bcd_ready,
    input  logic [BCD_BITS*MAX_DIGITS-1:0] bcd_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [CHAR_BITS-1:0]           m_digit_char,
    output logic                           m_last_digit
);

    localparam int BCD_W  = BCD_BITS * MAX_DIGITS;
    localparam int LEFT_W = $clog2(MAX_DIGITS + 1);

    emit_state_t state_reg, state_next;

    logic [BCD_W-1:0]     dig_reg, dig_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_BITS-1:0] m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;
    logic [BCD_BITS-1:0]  top_digit;
    logic                 out_free;

    assign top_digit = dig_reg[BCD_W-1 -: BCD_BITS];
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        dig_reg    <= dig_next;
        left_reg   <= left_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        bcd_ready    = 1'b0;
        case (state_reg)
            EM_IDLE: begin
                bcd_ready = 1'b1;
                if (bcd_valid) begin
                    dig_next   = bcd_data;
                    left_next  = LEFT_W'(MAX_DIGITS);
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP: begin
                // Drop leading zeros, but always keep the last digit.
                if (top_digit == '0 && left_reg != LEFT_W'(1)) begin
                    dig_next  = dig_reg << BCD_BITS;
                    left_next = left_reg - LEFT_W'(1);
                end else begin
                    state_next = EM_SEND;
                end
            end
            EM_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_ZERO + {{(CHAR_BITS-BCD_BITS){1'b0}}, top_digit};
                    m_last_next  = (left_reg == LEFT_W'(1));
                    dig_next     = dig_reg << BCD_BITS;
                    left_next    = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1)) begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_char_reg;
    assign m_last_digit = m_last_reg;

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter top level: double-dabble core feeding the digit emitter.
// Order: the first digit follows the input transfer through the shift of every input bit, the
// handoff, the skip of each leading zero and the final skip check, and the output register;
// then one digit per cycle while m_ready stays high.
// The core holds a finished value until the emitter takes it and then accepts the next, so
// the emitter sends one value while the next one converts.
// Reset (aresetn, synchronous, active low) returns both state machines to idle and
// drops any pending output; no other state survives between values.
module binary_to_decimal_ascii
    import bdasc_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_BITS-1:0]  m_digit_char,
    output logic                  m_last_digit
);

    logic                           bcd_valid;
    logic                           bcd_ready;
    logic [BCD_BITS*MAX_DIGITS-1:0] bcd_data;

    bdasc_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dabble (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_valid (s_valid),
        .start_ready (s_ready),
        .start_value (s_value[VALUE_WIDTH-1:0]),
        .bcd_valid   (bcd_valid),
        .bcd_ready   (bcd_ready),
        .bcd_data    (bcd_data)
    );

    bdasc_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bcd_valid    (bcd_valid),
        .bcd_ready    (bcd_ready),
        .bcd_data     (bcd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

endmodule

// ===== tb/bdasc_digit_checker.sv =====
// Watches both channels of the converter, predicts the decimal digit stream and checks it.
module bdasc_digit_checker
    import bdasc_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CHAR_BITS-1:0]  m_digit_char,
    input  logic                  m_last_digit,
    output int                    mismatches,
    output int                    pending,
    output int                    digits_seen
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] origin;
        logic [CHAR_BITS-1:0]  code;
        logic                  is_last;
    } ascii_digit_t;

    ascii_digit_t expected_digits[$];
    int fail_tally    = 0;
    int checked_tally = 0;

    // Queue the decimal text of one value: most significant kept digit first,
    // leading zeros dropped, a lone '0' for zero.
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] raw);
        logic [VALUE_BITS-1:0] mask;
        logic [VALUE_BITS-1:0] rest;
        logic [3:0]            dec [20];
        int                    kept;
        int                    top;
        ascii_digit_t          d;
        mask = (VALUE_WIDTH >= VALUE_BITS) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        rest = raw & mask;
        kept = (MAX_DIGITS > 20) ? 20 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
        for (int i = 0; i < kept; i++) begin
            dec[i] = 4'(rest % 64'd10);
            rest   = rest / 64'd10;
        end
        top = kept - 1;
        while (top > 0 && dec[top] == 4'd0)
            top--;
        for (int k = top; k >= 0; k--) begin
            d.origin  = raw;
            d.code    = ASCII_ZERO + CHAR_BITS'(dec[k]);
            d.is_last = (k == 0);
            expected_digits.push_back(d);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_tally++;
    endtask

    always @(posedge aclk) begin
        ascii_digit_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                queue_decimal_text(s_value);
            if (m_valid && m_ready) begin
                checked_tally++;
                if (expected_digits.size() == 0) begin
                    report_mismatch($sformatf("digit %0d arrived with nothing expected",
                                              m_digit_char));
                end else begin
                    want = expected_digits.pop_front();
                    if (m_digit_char !== want.code)
                        report_mismatch($sformatf("value %0d: digit_char %0d, want %0d",
                                                  want.origin, m_digit_char, want.code));
                    if (m_last_digit !== want.is_last)
                        report_mismatch($sformatf("value %0d: last_digit %0b, want %0b",
                                                  want.origin, m_last_digit, want.is_last));
                end
            end
        end
        mismatches  <= fail_tally;
        pending     <= expected_digits.size();
        digits_seen <= checked_tally;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the converter testbench: clock, reset, value stimulus, output back-pressure, verdict.
module tb;
    import bdasc_pkg::*;

    localparam int RANDOM_ITEMS = 190;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 150;

    typedef enum logic [1:0] {
        READY_STEADY,
        READY_COIN,
        READY_SPARSE,
        READY_BLOCKED
    } ready_mode_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAR_BITS-1:0]  m_digit_char;
    logic                  m_last_digit;

    int mismatches;
    int pending;
    int digits_seen;
    int cycle_count   = 0;
    int values_sent   = 0;
    int zeros_sent    = 0;
    int twenty_digits = 0;
    int burst_left    = 0;

    ready_mode_t ready_mode = READY_STEADY;
    int          ready_left = 0;

    binary_to_decimal_ascii uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    bdasc_digit_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit),
        .mismatches   (mismatches),
        .pending      (pending),
        .digits_seen  (digits_seen)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("timeout after %0d cycles, %0d digits still expected", cycle_count, pending);
        $display("simulation failed");
        $finish;
    end

    // Receiver back-pressure: switch between ready styles in runs of random length.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = (ready_mode == READY_BLOCKED) ? $urandom_range(1, 25)
                                                       : $urandom_range(10, 120);
        end
        ready_left--;
        case (ready_mode)
            READY_STEADY:  m_ready <= 1'b1;
            READY_COIN:    m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
            READY_BLOCKED: m_ready <= (ready_left == 0);
            default:       m_ready <= 1'b1;
        endcase
    end

    // Offer one value and hold it until the transfer; open a random gap, possibly none, between bursts.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        values_sent++;
        if (v == 64'd0)
            zeros_sent++;
        if (v >= 64'd10000000000000000000)
            twenty_digits++;
    endtask

    initial begin
        logic [VALUE_BITS-1:0] v;
        int                    roll;
        int                    width;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero, digit boundaries, powers of ten, widest values, bit patterns.
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'd1000);
        send_value(64'd42);
        send_value(64'd10203040506070809);
        send_value(64'd1000000000000000000);
        send_value(64'd9999999999999999999);
        send_value(64'd10000000000000000000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'h0000_0000_FFFF_FFFF);
        send_value(64'h0000_0001_0000_0000);
        send_value(64'h0000_0000_0000_FFFF);
        send_value(64'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                width = $urandom_range(1, 64);
                v     = {$urandom, $urandom} >> (64 - width);
            end else if (roll < 60) begin
                v = {$urandom, $urandom};
            end else if (roll < 75) begin
                // Neighbors of a power of ten: carries across every digit position.
                v = 64'd1;
                repeat ($urandom_range(0, 19)) v = v * 64'd10;
                v = v + 64'($urandom_range(0, 2)) - 64'd1;
            end else if (roll < 85) begin
                v = 64'($urandom_range(0, 1000));
            end else begin
                // Decimal text full of embedded zeros.
                v = 64'd0;
                repeat ($urandom_range(2, 19))
                    v = v * 64'd10 + (($urandom_range(0, 2) == 0) ?
                                      64'($urandom_range(1, 9)) : 64'd0);
            end
            send_value(v);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("converted %0d values (%0d zero, %0d of twenty digits) under random stalls,",
                 values_sent, zeros_sent, twenty_digits);
        $display("%0d digit characters compared, %0d mismatches", digits_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
